// File: hw/rtl/cellular_cave_smoother_assert.svh
// ---------------------------------------------------------------------------
// Cave smoother assertion macros
// Shorthand for the concurrent checks; the including module provides
// clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef CELLULAR_CAVE_SMOOTHER_ASSERT_SVH
`define CELLULAR_CAVE_SMOOTHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define CCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never be true
`define CCS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/ccs_pkg.sv
// ---------------------------------------------------------------------------
// Cave smoother package
// Grid geometry, field widths, codes, controller states and the control
// bundle between the controller and the column unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  // Grid geometry: the memory holds one column per word, one row per bit
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int NCOL_W   = $clog2(MAX_COLS + 1);
  localparam int NROW_W   = $clog2(MAX_ROWS + 1);

  // Field widths of the request and result
  localparam int FUNC_W   = 2;
  localparam int COLF_W   = 6;
  localparam int ROWF_W   = 6;
  localparam int SIZE_W   = 7;
  localparam int PASS_W   = 4;
  localparam int IDX_W    = 2;

  // Smoothing thresholds: above HIGH becomes wall, below KEEP becomes floor
  localparam logic [3:0] WALL_HIGH = 4'd4;
  localparam logic [3:0] WALL_KEEP = 4'd4;

  // Register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 7'd64;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 7'd64;
  localparam logic [PASS_W-1:0] PASSES_RST = 4'd5;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SMOOTH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SMOOTH_PASSES = 2'd2;

  // Result kinds
  localparam logic RK_READ = 1'b0;
  localparam logic RK_DONE = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MOD,
    ST_RD_RESP,
    ST_SM_INIT,
    ST_SM_CUR,
    ST_SM_FETCH,
    ST_SM_NXT,
    ST_SM_ROWS,
    ST_SM_WB,
    ST_DONE
  } ccs_state_t;

  // Controller to column unit
  typedef struct packed {
    logic init;      // prev <= walls, cur <= memory word
    logic load_nxt;  // nxt <= memory word or walls, restart row count
    logic has_nxt;   // a next column exists inside the active area
    logic step;      // update one row of the current column
    logic shift;     // slide the three-column window by one
  } ccs_col_ctl_t;

  // Column unit to controller
  typedef struct packed {
    logic             row_last;
    logic [ROW_W-1:0] row;
  } ccs_col_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/cellular_cave_smoother.sv
// ---------------------------------------------------------------------------
// Cave smoother top level
// Wall/floor grid in a column-word memory with cell write, cell read and
// in-place 4-5 rule smoothing passes.
//
//   channel  dir  handshake          payload
//   in_      in   in_tvalid/tready   tuser: func; tdata: col, row, cell_in
//   out_     out  out_tvalid/tready  tuser: result_kind; tdata: cell_out
//   cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
// Cell write and cell read each do a memory read, then modify and write
// back or answer. A smooth request runs its passes column by column
// through the single column memory port and the rule unit, which rewrites
// one row per cycle. After reset a clearing pass zeroes all MAX_COLS
// memory words; no request is taken until it ends, configuration writes
// always are. A result waiting at the output holds the controller in its
// answer state.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cellular_cave_smoother_assert.svh"

module cellular_cave_smoother
  import ccs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // [5:0] col, [11:6] row, [12] cell_in
  input  wire logic [1:0]   in_tuser,   // [1:0] func
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [7:0]   out_tdata,  // [0] cell_out
  output logic      [0:0]   out_tuser,  // [0] result_kind
  // configuration channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [6:0]   cfg_data
);

  // Configuration registers
  logic [SIZE_W-1:0] grid_width_r;
  logic [SIZE_W-1:0] grid_height_r;
  logic [PASS_W-1:0] smooth_passes_r;

  // Controller
  ccs_state_t        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;

  // Request capture
  logic [COL_W-1:0]  req_col_r;
  logic [ROW_W-1:0]  req_row_r;
  logic              req_cell_r;
  logic              req_inside_r;
  logic              req_load;

  // Output register
  logic              out_tvalid_r;
  logic              out_kind_r;
  logic              out_cell_r;
  logic              out_load;
  logic              out_kind_nxt;
  logic              out_cell_nxt;
  logic              out_free;

  // Memory port
  logic                ram_wr_en;
  logic [COL_W-1:0]    ram_wr_addr;
  logic [MAX_ROWS-1:0] ram_wr_data;
  logic                ram_rd_en;
  logic [COL_W-1:0]    ram_rd_addr;
  logic [MAX_ROWS-1:0] ram_rd_data;
  logic [MAX_ROWS-1:0] mod_word;

  // Column unit
  ccs_col_ctl_t        col_ctl;
  ccs_col_sts_t        col_sts;
  logic [MAX_ROWS-1:0] cur_word;

  // Request fields
  logic [FUNC_W-1:0] fld_func;
  logic [COLF_W-1:0] fld_col;
  logic [ROWF_W-1:0] fld_row;
  logic              fld_cell;
  logic              in_acc;
  logic              in_inside;

  // Active area
  logic [NCOL_W-1:0] ncols;
  logic [NROW_W-1:0] nrows;
  logic              has_nxt;
  logic              last_pass;

  assign fld_func = in_tuser[1:0];
  assign fld_col  = in_tdata[5:0];
  assign fld_row  = in_tdata[11:6];
  assign fld_cell = in_tdata[12];

  // Saturate the size registers at the memory geometry
  assign ncols = (32'(grid_width_r) > MAX_COLS) ? NCOL_W'(MAX_COLS) : NCOL_W'(grid_width_r);
  assign nrows = (32'(grid_height_r) > MAX_ROWS) ? NROW_W'(MAX_ROWS)
                                                 : NROW_W'(grid_height_r);

  assign in_inside = (32'(fld_col) < 32'(ncols)) && (32'(fld_row) < 32'(nrows));
  assign in_acc    = in_tvalid && in_tready;
  assign has_nxt   = (NCOL_W'(col_r) + NCOL_W'(1)) < ncols;
  assign last_pass = ({1'b0, pass_r} + (PASS_W+1)'(1)) == {1'b0, smooth_passes_r};
  assign out_free  = !out_tvalid_r || out_tready;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= WIDTH_RST;
      grid_height_r   <= HEIGHT_RST;
      smooth_passes_r <= PASSES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:    grid_width_r    <= cfg_data;
        CFG_GRID_HEIGHT:   grid_height_r   <= cfg_data;
        CFG_SMOOTH_PASSES: smooth_passes_r <= cfg_data[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell write merges the new bit into the column word
  always_comb begin
    mod_word            = ram_rd_data;
    mod_word[req_row_r] = req_cell_r;
  end

  // Next state and datapath controls
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    pass_nxt     = pass_r;
    in_tready    = 1'b0;
    req_load     = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = col_r;
    ram_wr_data  = cur_word;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = col_r;
    out_load     = 1'b0;
    out_kind_nxt = RK_READ;
    out_cell_nxt = 1'b0;
    col_ctl      = '0;
    col_ctl.has_nxt = has_nxt;

    unique case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        if (32'(col_r) == MAX_COLS - 1) begin
          col_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end

      ST_IDLE: begin
        in_tready   = 1'b1;
        ram_rd_addr = COL_W'(fld_col);
        if (in_acc) begin
          req_load = 1'b1;
          unique case (fld_func)
            FUNC_WRITE: begin
              ram_rd_en = 1'b1;
              state_nxt = ST_WR_MOD;
            end
            FUNC_READ: begin
              ram_rd_en = 1'b1;
              state_nxt = ST_RD_RESP;
            end
            FUNC_SMOOTH: begin
              col_nxt  = '0;
              pass_nxt = '0;
              if (ncols == '0 || nrows == '0 || smooth_passes_r == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SM_INIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_WR_MOD: begin
        ram_wr_en   = req_inside_r;
        ram_wr_addr = req_col_r;
        ram_wr_data = mod_word;
        state_nxt   = ST_IDLE;
      end

      ST_RD_RESP: begin
        out_kind_nxt = RK_READ;
        out_cell_nxt = req_inside_r & ram_rd_data[req_row_r];
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // Fetch the first column of a pass
      ST_SM_INIT: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
        col_nxt     = '0;
        state_nxt   = ST_SM_CUR;
      end

      ST_SM_CUR: begin
        col_ctl.init = 1'b1;
        state_nxt    = ST_SM_FETCH;
      end

      // Fetch the column to the right, if inside the area
      ST_SM_FETCH: begin
        ram_rd_en   = has_nxt;
        ram_rd_addr = col_r + COL_W'(1);
        state_nxt   = ST_SM_NXT;
      end

      ST_SM_NXT: begin
        col_ctl.load_nxt = 1'b1;
        state_nxt        = ST_SM_ROWS;
      end

      ST_SM_ROWS: begin
        col_ctl.step = 1'b1;
        if (col_sts.row_last) begin
          state_nxt = ST_SM_WB;
        end
      end

      // Write the finished column back and slide the window
      ST_SM_WB: begin
        ram_wr_en     = 1'b1;
        col_ctl.shift = 1'b1;
        if (has_nxt) begin
          col_nxt   = col_r + COL_W'(1);
          state_nxt = ST_SM_FETCH;
        end else if (last_pass) begin
          state_nxt = ST_DONE;
        end else begin
          pass_nxt  = pass_r + PASS_W'(1);
          state_nxt = ST_SM_INIT;
        end
      end

      ST_DONE: begin
        out_kind_nxt = RK_DONE;
        out_cell_nxt = 1'b0;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      col_r   <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (req_load) begin
      req_col_r    <= COL_W'(fld_col);
      req_row_r    <= ROW_W'(fld_row);
      req_cell_r   <= fld_cell;
      req_inside_r <= in_inside;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_cell_r <= out_cell_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_cell_r};
  assign out_tuser  = out_kind_r;

  // Grid memory: one word per column, one bit per row
  ccs_ram #(
    .WIDTH (MAX_ROWS),
    .DEPTH (MAX_COLS)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Three-column window and rule
  ccs_col_unit u_col_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (col_ctl),
    .nrows    (nrows),
    .rd_data  (ram_rd_data),
    .cur_word (cur_word),
    .sts      (col_sts)
  );

  // Checks
  `CCS_ASSERT_NEVER(a_ram_one_access, ram_wr_en && ram_rd_en, "memory read and write collide")
  `CCS_ASSERT_IMP(a_out_no_overwrite, out_load, !out_tvalid_r || out_tready, "pending result overwritten")
  `CCS_ASSERT_IMP(a_row_in_area, state_r == ST_SM_ROWS, NROW_W'(col_sts.row) < nrows, "row past active area")
  `CCS_ASSERT_IMP(a_wb_in_area, state_r == ST_SM_WB, NCOL_W'(col_r) < ncols, "write back past active area")

endmodule

`default_nettype wire

// File: hw/rtl/ccs_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered; the read data
// holds while no read is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ccs_col_unit.sv
// ---------------------------------------------------------------------------
// Cave smoother column unit
// Holds a three-column window (updated left column, column in work,
// untouched right column) and rewrites the column in work one row per
// cycle under the 4-5 rule, top row first.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_col_unit
  import ccs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ccs_col_ctl_t        ctl,
  input  wire logic [NROW_W-1:0]   nrows,
  input  wire logic [MAX_ROWS-1:0] rd_data,
  output logic      [MAX_ROWS-1:0] cur_word,
  output ccs_col_sts_t             sts
);

  logic [MAX_ROWS-1:0] prev_r;
  logic [MAX_ROWS-1:0] cur_r;
  logic [MAX_ROWS-1:0] nxt_r;
  logic [ROW_W-1:0]    row_r;

  logic             at_top;
  logic             at_bot;
  logic [ROW_W-1:0] row_up;
  logic [ROW_W-1:0] row_dn;
  logic [7:0]       nbr;
  logic [3:0]       wall_cnt;
  logic             new_bit;

  // Row neighbors; anything past the active rows reads as wall
  assign at_top = (row_r == '0);
  assign at_bot = ((NROW_W'(row_r) + NROW_W'(1)) >= nrows);
  assign row_up = row_r - ROW_W'(1);
  assign row_dn = row_r + ROW_W'(1);

  assign nbr[0] = at_top | prev_r[row_up];
  assign nbr[1] = prev_r[row_r];
  assign nbr[2] = at_bot | prev_r[row_dn];
  assign nbr[3] = at_top | cur_r[row_up];
  assign nbr[4] = at_bot | cur_r[row_dn];
  assign nbr[5] = at_top | nxt_r[row_up];
  assign nbr[6] = nxt_r[row_r];
  assign nbr[7] = at_bot | nxt_r[row_dn];

  // Count walls around the cell
  always_comb begin
    wall_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      wall_cnt = wall_cnt + 4'(nbr[i]);
    end
  end

  // Apply the rule: exactly four keeps the cell
  always_comb begin
    if (wall_cnt > WALL_HIGH) begin
      new_bit = 1'b1;
    end else if (wall_cnt < WALL_KEEP) begin
      new_bit = 1'b0;
    end else begin
      new_bit = cur_r[row_r];
    end
  end

  // Column window
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      prev_r <= '1;
      cur_r  <= rd_data;
    end else if (ctl.shift) begin
      prev_r <= cur_r;
      cur_r  <= nxt_r;
    end else if (ctl.step) begin
      cur_r[row_r] <= new_bit;
    end
    if (ctl.load_nxt) begin
      nxt_r <= ctl.has_nxt ? rd_data : '1;
    end
  end

  // Row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (ctl.load_nxt) begin
      row_r <= '0;
    end else if (ctl.step) begin
      row_r <= row_r + ROW_W'(1);
    end
  end

  assign cur_word     = cur_r;
  assign sts.row_last = at_bot;
  assign sts.row      = row_r;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Cave smoother testbench
// Drives cell write, cell read and smoothing requests into the grid block,
// rebuilds the grid and the 4-5 smoothing rule on the bench side, and checks
// every result in order. A short scripted run covers the grid corners, the
// area limits and the register extremes; random requests under changing
// sizes and handshake pressure follow.
// ----------------------------------------------------------------------------
module testbench
  import ccs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0]  CFG_UNUSED  = 2'd3;

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int SMOOTH_BUDGET   = 8000;
  localparam int BLOCK_COUNT     = 28;
  localparam int BLOCK_REQUESTS  = 50;
  localparam int SCRIPT_LEN      = 25;

  typedef struct packed {
    logic kind;
    logic wall;
  } cave_result_t;

  typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [1:0]  code;      // function code or register index
    logic [5:0]  col;
    logic [5:0]  row;
    logic        fill;
    logic [6:0]  value;
    logic        pinned;    // result typed into the script
    logic        exp_kind;
    logic        exp_cell;
  } script_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  // Bench copy of the grid and its registers
  bit                cave_map [MAX_COLS][MAX_ROWS];
  logic [SIZE_W-1:0] map_width  = WIDTH_RST;
  logic [SIZE_W-1:0] map_height = HEIGHT_RST;
  logic [PASS_W-1:0] pass_count = PASSES_RST;

  cave_result_t awaited_results [$];
  cave_result_t pinned_result;
  bit           pinned_valid = 1'b0;
  int           error_count = 0;
  int           quiet_cycles = 0;
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  bit           hold_req = 1'b0;

  cellular_cave_smoother uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [5:0] col, [11:6] row, [12] cell_in
    .in_tuser   (in_tuser),   // [1:0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] cell_out
    .out_tuser  (out_tuser),  // [0] result_kind
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp a size register to the grid dimension
  function automatic int span(logic [SIZE_W-1:0] size, int cap);
    return (size > cap) ? cap : int'(size);
  endfunction

  // One in-place pass, columns outer, rows inner; outside cells count as walls
  function automatic void smooth_pass(int nc, int nr);
    int walls;
    int x;
    int y;
    for (int c = 0; c < nc; c++) begin
      for (int r = 0; r < nr; r++) begin
        walls = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          for (int dr = -1; dr <= 1; dr++) begin
            x = c + dc;
            y = r + dr;
            if (dc != 0 || dr != 0) begin
              if (x < 0 || y < 0 || x >= nc || y >= nr) walls++;
              else walls += cave_map[x][y];
            end
          end
        end
        if (walls > WALL_HIGH) cave_map[c][r] = 1'b1;
        else if (walls < WALL_KEEP) cave_map[c][r] = 1'b0;
      end
    end
  endfunction

  // Apply one request to the bench grid; return 1 when it yields a result
  function automatic bit run_request(input logic [1:0] code, input logic [5:0] c,
                                     input logic [5:0] r, input logic v,
                                     output cave_result_t res);
    int nc;
    int nr;
    bit hit;
    nc = span(map_width, MAX_COLS);
    nr = span(map_height, MAX_ROWS);
    hit = (c < nc) && (r < nr);
    res.kind = RK_READ;
    res.wall = 1'b0;
    case (code)
      FUNC_WRITE: begin
        if (hit) cave_map[c][r] = v;
        return 1'b0;
      end
      FUNC_SMOOTH: begin
        repeat (pass_count) smooth_pass(nc, nr);
        res.kind = RK_DONE;
        return 1'b1;
      end
      FUNC_READ: begin
        if (hit) res.wall = cave_map[c][r];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void set_register(logic [IDX_W-1:0] idx, logic [6:0] value);
    case (idx)
      CFG_GRID_WIDTH:    map_width = value;
      CFG_GRID_HEIGHT:   map_height = value;
      CFG_SMOOTH_PASSES: pass_count = value[PASS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic script_step_t request_step(logic [1:0] code, logic [5:0] c,
                                                logic [5:0] r, logic v);
    script_step_t s;
    s = '0;
    s.kind = STEP_REQUEST;
    s.code = code;
    s.col  = c;
    s.row  = r;
    s.fill = v;
    return s;
  endfunction

  function automatic script_step_t checked_step(logic [1:0] code, logic [5:0] c,
                                                logic [5:0] r, logic kind, logic wall);
    script_step_t s;
    s = request_step(code, c, r, 1'b0);
    s.pinned   = 1'b1;
    s.exp_kind = kind;
    s.exp_cell = wall;
    return s;
  endfunction

  function automatic script_step_t config_step(logic [1:0] idx, logic [6:0] value);
    script_step_t s;
    s = '0;
    s.kind  = STEP_CONFIG;
    s.code  = idx;
    s.value = value;
    return s;
  endfunction

  // Mostly small sizes, now and then full, oversized or empty
  function automatic logic [SIZE_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return SIZE_W'($urandom_range(8, 1));
    if (pick < 85) return SIZE_W'($urandom_range(64, 9));
    if (pick < 92) return 7'd64;
    if (pick < 97) return SIZE_W'($urandom_range(127, 65));
    return 7'd0;
  endfunction

  // Offer one request, idling at random first; return at the falling edge
  task automatic offer_request(input logic [1:0] code, input logic [5:0] c,
                               input logic [5:0] r, input logic v);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= code;
    in_tdata  <= {3'b000, v, r, c};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  // Hold the register write until taken; the caller drops cfg_valid later
  task automatic write_register(input logic [1:0] idx, input logic [6:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
  endtask

  // Stop offering and wait until every awaited result is in and writes settle
  task automatic drain_results();
    cfg_valid <= 1'b0;
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Check results against the oldest expectation, then predict new requests
  always @(posedge clk) begin : monitor
    cave_result_t got;
    cave_result_t want;
    cave_result_t predicted;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[0];
        got.wall = out_tdata[0];
        if (awaited_results.size() == 0) begin
          $error("result with none awaited: result_kind %0b cell_out %0b",
                 got.kind, got.wall);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind) begin
            $error("result_kind: expected %0b, actual %0b", want.kind, got.kind);
            error_count++;
          end
          if (got.wall !== want.wall) begin
            $error("cell_out: expected %0b, actual %0b", want.wall, got.wall);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (run_request(in_tuser, in_tdata[5:0], in_tdata[11:6], in_tdata[12], predicted))
          awaited_results.push_back(pinned_valid ? pinned_result : predicted);
      end
      if (cfg_valid && cfg_ready) set_register(cfg_index, cfg_data);
    end
  end

  // Count cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: random stalls, or one long hold-off when asked
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    script_step_t      script [SCRIPT_LEN];
    script_step_t      step;
    bit                last_was_config;
    int                sent;
    int                nc;
    int                nr;
    int                cap;
    int                pick;
    logic [1:0]        code;
    logic [5:0]        c;
    logic [5:0]        r;
    logic              v;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;

    script = '{
      checked_step(FUNC_READ, 6'd0, 6'd0, RK_READ, 1'b0),
      request_step(FUNC_WRITE, 6'd0, 6'd0, 1'b1),
      request_step(FUNC_WRITE, 6'd63, 6'd63, 1'b1),
      checked_step(FUNC_READ, 6'd0, 6'd0, RK_READ, 1'b1),
      request_step(FUNC_UNUSED, 6'd63, 6'd63, 1'b0),
      checked_step(FUNC_READ, 6'd63, 6'd63, RK_READ, 1'b1),
      config_step(CFG_GRID_WIDTH, 7'd4),
      config_step(CFG_GRID_HEIGHT, 7'd3),
      config_step(CFG_SMOOTH_PASSES, 7'd0),
      checked_step(FUNC_SMOOTH, 6'd0, 6'd0, RK_DONE, 1'b0),
      request_step(FUNC_WRITE, 6'd5, 6'd2, 1'b1),
      checked_step(FUNC_READ, 6'd63, 6'd63, RK_READ, 1'b0),
      config_step(CFG_SMOOTH_PASSES, 7'd15),
      checked_step(FUNC_SMOOTH, 6'd0, 6'd0, RK_DONE, 1'b0),
      request_step(FUNC_READ, 6'd1, 6'd1, 1'b0),
      config_step(CFG_GRID_WIDTH, 7'd0),
      request_step(FUNC_WRITE, 6'd0, 6'd0, 1'b0),
      checked_step(FUNC_READ, 6'd0, 6'd0, RK_READ, 1'b0),
      checked_step(FUNC_SMOOTH, 6'd0, 6'd0, RK_DONE, 1'b0),
      config_step(CFG_UNUSED, 7'd127),
      config_step(CFG_GRID_WIDTH, 7'd127),
      config_step(CFG_GRID_HEIGHT, 7'd64),
      checked_step(FUNC_READ, 6'd63, 6'd63, RK_READ, 1'b1),
      config_step(CFG_SMOOTH_PASSES, 7'd1),
      checked_step(FUNC_SMOOTH, 6'd0, 6'd0, RK_DONE, 1'b0)
    };

    // Hold reset, then release at a falling edge
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Scripted run, no idling
    last_was_config = 1'b0;
    foreach (script[i]) begin
      step = script[i];
      if (step.kind == STEP_CONFIG) begin
        if (!last_was_config) drain_results();
        write_register(step.code, step.value);
        last_was_config = 1'b1;
      end else begin
        pinned_valid  = step.pinned;
        pinned_result = '{step.exp_kind, step.exp_cell};
        offer_request(step.code, step.col, step.row, step.fill);
        pinned_valid  = 1'b0;
        last_was_config = 1'b0;
      end
    end

    // Random run: reconfigure per block, idling pattern per phase
    for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
      case (blk / (BLOCK_COUNT / 4))
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 62; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 62; end
        default: begin sender_idle_pct = 15; stall_pct = 15; end
      endcase

      drain_results();
      w = pick_size();
      h = pick_size();
      nc = span(w, MAX_COLS);
      nr = span(h, MAX_ROWS);
      // keep the smoothing time bounded on large areas
      cap = SMOOTH_BUDGET / (nc * (nr + 3) + 2);
      if (cap > 15) cap = 15;
      write_register(CFG_GRID_WIDTH, w);
      write_register(CFG_GRID_HEIGHT, h);
      write_register(CFG_SMOOTH_PASSES, 7'($urandom_range(cap)));
      if ($urandom_range(3) == 0) write_register(CFG_UNUSED, 7'($urandom));

      // block the result side for a long stretch while requests keep coming
      if (blk == 2) hold_req = 1'b1;

      sent = 0;
      while (sent < BLOCK_REQUESTS) begin
        pick = $urandom_range(99);
        if (pick < 52) code = FUNC_WRITE;
        else if (pick < 92) code = FUNC_READ;
        else if (pick < 96) code = FUNC_SMOOTH;
        else code = FUNC_UNUSED;
        if (nc != 0 && nr != 0 && $urandom_range(9) != 0) begin
          c = 6'($urandom_range(nc - 1));
          r = 6'($urandom_range(nr - 1));
        end else begin
          c = 6'($urandom);
          r = 6'($urandom);
        end
        v = ($urandom_range(99) < 45);
        offer_request(code, c, r, v);
        if (code != FUNC_UNUSED && !(code == FUNC_WRITE && (c >= nc || r >= nr))) sent++;
      end
    end

    drain_results();
    if (error_count == 0 && awaited_results.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
